FILE: design/sspr_pkg.sv
// Shared constants for the servo status packet receiver: parse phases, verdict codes, reset values.
package sspr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned STATUS_W = 3;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ID    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ERR   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PARAM = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CSUM  = 3'd5;

    // Verdict codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SERVOERR = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd5;

    // Result kinds.
    localparam logic KIND_PARAM   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_EXPECTED_ID     = 1'b0;
    localparam logic REG_EXPECTED_PARAMS = 1'b1;

    // Framing bytes and register reset values.
    localparam logic [BYTE_W-1:0] SYNC_BYTE            = 8'hFF;
    localparam logic [BYTE_W-1:0] HEADER_LEN           = 8'h02;
    localparam logic [BYTE_W-1:0] RST_EXPECTED_ID      = 8'h01;
    localparam logic [BYTE_W-1:0] RST_EXPECTED_PARAMS  = 8'h4A;

endpackage

FILE: design/servo_status_packet_receiver_core.sv
// Status packet parser for a half-duplex serial servo bus, one received byte per item.
// A result is registered and presented in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the output slot is free; the single output register passes ready through,
// so a new byte is taken in the same cycle that a waiting result is taken.
// Reset (synchronous, active low) returns the parser to sync hunting, clears the
// output valid and restores expected_id to 1 and expected_params to 74.
module servo_status_packet_receiver_core
    import sspr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [BYTE_W-1:0]   i_cfg_data,
    // Received byte channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [BYTE_W-1:0]   o_offset,
    output logic [BYTE_W-1:0]   o_data,
    output logic [STATUS_W-1:0] o_status,
    output logic [BYTE_W-1:0]   o_servo_error
);

    // Configuration registers.
    logic [BYTE_W-1:0]   r_expected_id;
    logic [BYTE_W-1:0]   r_expected_params;

    // Parser state.
    logic [PHASE_W-1:0]  r_phase,    n_phase;
    logic                r_first_ff, n_first_ff;
    logic [BYTE_W-1:0]   r_len,      n_len;
    logic [BYTE_W-1:0]   r_err,      n_err;
    logic [BYTE_W-1:0]   r_sum,      n_sum;
    logic [BYTE_W-1:0]   r_idx,      n_idx;
    logic                r_id_bad,   n_id_bad;

    // Output register.
    logic                r_out_valid;
    logic                r_kind,     n_kind;
    logic [BYTE_W-1:0]   r_offset,   n_offset;
    logic [BYTE_W-1:0]   r_data,     n_data;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic [BYTE_W-1:0]   r_serr,     n_serr;
    logic                n_emit;

    logic                in_fire;
    logic [BYTE_W-1:0]   param_count;
    logic [BYTE_W-1:0]   idx_inc;

    // The output slot is free when it is empty or being drained this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // Number of parameter bytes that the LENGTH field announces.
    assign param_count = r_len - HEADER_LEN;
    assign idx_inc     = r_idx + 8'd1;

    // Next-state and result logic for one accepted byte.
    always_comb begin
        n_phase    = r_phase;
        n_first_ff = r_first_ff;
        n_len      = r_len;
        n_err      = r_err;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_id_bad   = r_id_bad;
        n_emit     = 1'b0;
        n_kind     = KIND_VERDICT;
        n_offset   = '0;
        n_data     = '0;
        n_status   = ST_OK;
        n_serr     = r_err;

        case (r_phase)
            PH_HUNT: begin
                // Two sync bytes in a row open a packet.
                if (i_rx_byte == SYNC_BYTE) begin
                    if (r_first_ff) begin
                        n_phase = PH_ID;
                    end else begin
                        n_first_ff = 1'b1;
                    end
                end else begin
                    n_first_ff = 1'b0;
                end
            end
            PH_ID: begin
                // Any byte here is the ID, a sync value included.
                n_id_bad = (i_rx_byte != r_expected_id);
                n_sum    = i_rx_byte;
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_ERR;
            end
            PH_ERR: begin
                n_err = i_rx_byte;
                n_serr = i_rx_byte;
                n_sum = r_sum + i_rx_byte;
                n_idx = '0;
                // ID and length failures are reported here and carry the error byte.
                if (r_id_bad) begin
                    n_emit   = 1'b1;
                    n_status = ST_BAD_ID;
                end else if (r_len < HEADER_LEN) begin
                    n_emit   = 1'b1;
                    n_status = ST_SHORT;
                end else if (r_len == HEADER_LEN) begin
                    n_phase = PH_CSUM;
                end else begin
                    n_phase = PH_PARAM;
                end
            end
            PH_PARAM: begin
                n_emit   = 1'b1;
                n_kind   = KIND_PARAM;
                n_offset = r_idx;
                n_data   = i_rx_byte;
                n_serr   = '0;
                n_sum    = r_sum + i_rx_byte;
                n_idx    = idx_inc;
                if (idx_inc == param_count) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                n_emit = 1'b1;
                if (i_rx_byte != ~r_sum) begin
                    n_status = ST_CHECKSUM;
                end else if (r_err != '0) begin
                    n_status = ST_SERVOERR;
                end else if (param_count != r_expected_params) begin
                    n_status = ST_SIZE;
                end else begin
                    n_status = ST_OK;
                end
            end
            default: begin
                n_phase    = PH_HUNT;
                n_first_ff = 1'b0;
            end
        endcase

        // Every verdict sends the parser back to hunting for sync.
        if (n_emit && (n_kind == KIND_VERDICT)) begin
            n_phase    = PH_HUNT;
            n_first_ff = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id     <= RST_EXPECTED_ID;
            r_expected_params <= RST_EXPECTED_PARAMS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EXPECTED_ID:     r_expected_id     <= i_cfg_data;
                REG_EXPECTED_PARAMS: r_expected_params <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_first_ff <= 1'b0;
            r_len      <= '0;
            r_err      <= '0;
            r_sum      <= '0;
            r_idx      <= '0;
            r_id_bad   <= 1'b0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_first_ff <= n_first_ff;
            r_len      <= n_len;
            r_err      <= n_err;
            r_sum      <= n_sum;
            r_idx      <= n_idx;
            r_id_bad   <= n_id_bad;
        end
    end

    // Output valid: set by a byte that yields a result, cleared when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it only loads with a new result.
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_kind   <= n_kind;
            r_offset <= n_offset;
            r_data   <= n_data;
            r_status <= n_status;
            r_serr   <= n_serr;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_offset      = r_offset;
    assign o_data        = r_data;
    assign o_status      = r_status;
    assign o_servo_error = r_serr;

endmodule

FILE: dv/sspr_tb_pkg.sv
`timescale 1ns / 1ps
// Expected-result tracking for the servo status packet receiver testbench.
package sspr_tb_pkg;

    import sspr_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   offset;
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   servo_error;
    } servo_result_t;

    class status_parse_checker;

        // Register copies, updated together with every write to the block.
        logic [BYTE_W-1:0]   want_id;
        logic [BYTE_W-1:0]   want_params;

        // Parser state mirrored byte by byte.
        logic [PHASE_W-1:0]  phase;
        bit                  ff_seen;
        bit                  id_mismatch;
        logic [BYTE_W-1:0]   pkt_len;
        logic [BYTE_W-1:0]   err_byte;
        logic [BYTE_W-1:0]   sum;
        logic [BYTE_W-1:0]   idx;

        servo_result_t       due_results[$];

        int unsigned         bytes_seen;
        int unsigned         params_seen;
        int unsigned         verdicts[8];
        int unsigned         fail_count;

        function new();
            want_id     = RST_EXPECTED_ID;
            want_params = RST_EXPECTED_PARAMS;
            phase       = PH_HUNT;
            ff_seen     = 1'b0;
            id_mismatch = 1'b0;
            pkt_len     = '0;
            err_byte    = '0;
            sum         = '0;
            idx         = '0;
            bytes_seen  = 0;
            params_seen = 0;
            fail_count  = 0;
            foreach (verdicts[i]) verdicts[i] = 0;
        endfunction

        function void set_reg(logic index, logic [BYTE_W-1:0] value);
            if (index == REG_EXPECTED_ID) want_id = value;
            else                          want_params = value;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void push_verdict(logic [STATUS_W-1:0] code);
            servo_result_t r;
            r = '{kind: KIND_VERDICT, offset: '0, data: '0, status: code,
                  servo_error: err_byte};
            due_results.push_back(r);
            phase   = PH_HUNT;
            ff_seen = 1'b0;
        endfunction

        // Advance the mirrored parser by one accepted byte.
        function void parse_byte(logic [BYTE_W-1:0] b);
            servo_result_t r;
            bytes_seen++;
            case (phase)
                PH_HUNT: begin
                    if (b == SYNC_BYTE) begin
                        if (ff_seen) phase = PH_ID;
                        else         ff_seen = 1'b1;
                    end else begin
                        ff_seen = 1'b0;
                    end
                end
                PH_ID: begin
                    id_mismatch = (b != want_id);
                    sum         = b;
                    phase       = PH_LEN;
                end
                PH_LEN: begin
                    pkt_len = b;
                    sum     = sum + b;
                    phase   = PH_ERR;
                end
                PH_ERR: begin
                    err_byte = b;
                    sum      = sum + b;
                    idx      = '0;
                    if (id_mismatch)                push_verdict(ST_BAD_ID);
                    else if (pkt_len < HEADER_LEN)  push_verdict(ST_SHORT);
                    else if (pkt_len == HEADER_LEN) phase = PH_CSUM;
                    else                            phase = PH_PARAM;
                end
                PH_PARAM: begin
                    // Parameter items carry a zero status and no servo error.
                    r = '{kind: KIND_PARAM, offset: idx, data: b, status: ST_OK,
                          servo_error: '0};
                    due_results.push_back(r);
                    sum = sum + b;
                    idx = idx + 1'b1;
                    if (idx == BYTE_W'(pkt_len - HEADER_LEN)) phase = PH_CSUM;
                end
                PH_CSUM: begin
                    if (b != BYTE_W'(~sum))                           push_verdict(ST_CHECKSUM);
                    else if (err_byte != '0)                          push_verdict(ST_SERVOERR);
                    else if (BYTE_W'(pkt_len - HEADER_LEN) != want_params)
                        push_verdict(ST_SIZE);
                    else                                              push_verdict(ST_OK);
                end
                default: begin
                    phase   = PH_HUNT;
                    ff_seen = 1'b0;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void match_result(logic kind, logic [BYTE_W-1:0] offset,
                                   logic [BYTE_W-1:0] data, logic [STATUS_W-1:0] status,
                                   logic [BYTE_W-1:0] servo_error);
            servo_result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d offset %0d data %0d status %0d error %0d",
                       kind, offset, data, status, servo_error);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (want.kind == KIND_VERDICT) verdicts[want.status]++;
            else                           params_seen++;
            compare_field("kind", BYTE_W'(want.kind), BYTE_W'(kind));
            compare_field("offset", want.offset, offset);
            compare_field("data", want.data, data);
            compare_field("status", BYTE_W'(want.status), BYTE_W'(status));
            compare_field("servo_error", want.servo_error, servo_error);
        endfunction

    endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the servo status packet receiver core.
module tb_top;

    import sspr_pkg::*;
    import sspr_tb_pkg::*;

    // The run is split into register settings; each one streams roughly this
    // many bytes, and a packet may straddle two settings.
    localparam int unsigned NUM_SETTINGS    = 12;
    localparam int unsigned BYTES_PER_SET   = 150;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_index   = REG_EXPECTED_ID;
    logic [BYTE_W-1:0]   i_cfg_data    = '0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [BYTE_W-1:0]   i_rx_byte     = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic                o_kind;
    logic [BYTE_W-1:0]   o_offset;
    logic [BYTE_W-1:0]   o_data;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_servo_error;

    servo_status_packet_receiver_core u_dut (.*);

    status_parse_checker tracker = new();

    // Bytes waiting to be sent, in line order.
    logic [BYTE_W-1:0] byte_stream[$];

    // Values last written to the registers; the packet generator aims at them.
    logic [BYTE_W-1:0] cur_id     = RST_EXPECTED_ID;
    logic [BYTE_W-1:0] cur_params = RST_EXPECTED_PARAMS;

    // Idle probabilities in percent: gap_pct for the byte sender, stall_pct
    // for the result receiver.
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle length: mostly none, otherwise mostly short with the odd long one.
    function automatic int unsigned pick_wait(int unsigned pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0)    return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result side. Outputs are sampled at the edge, before this edge's updates,
    // and ready is redriven once per edge. A stall holds ready low, and ready is
    // driven high again between stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.match_result(o_kind, o_offset, o_data, o_status, o_servo_error);
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_wait(stall_pct);
        end
    end

    // Append one status packet. A length below two ends the packet at the
    // error byte, since the block gives its verdict there.
    function automatic void append_packet(logic [BYTE_W-1:0] id, logic [BYTE_W-1:0] len,
                                          logic [BYTE_W-1:0] err, bit good_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int unsigned       n;
        byte_stream.push_back(SYNC_BYTE);
        byte_stream.push_back(SYNC_BYTE);
        byte_stream.push_back(id);
        byte_stream.push_back(len);
        byte_stream.push_back(err);
        if (len < HEADER_LEN) return;
        sum = id + len + err;
        n   = 32'(len - HEADER_LEN);
        for (int i = 0; i < n; i++) begin
            b   = BYTE_W'($urandom_range(0, 255));
            sum = sum + b;
            byte_stream.push_back(b);
        end
        if (good_sum) byte_stream.push_back(~sum);
        else          byte_stream.push_back(~sum ^ BYTE_W'($urandom_range(1, 255)));
    endfunction

    // Random packet aimed at the current settings: mostly well formed with
    // random content, with line noise, wrong IDs, odd lengths, servo errors,
    // bad checksums and the occasional packet cut short.
    function automatic void gen_packet();
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] err;
        int unsigned       pick;
        int unsigned       start;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                byte_stream.push_back(($urandom_range(0, 19) == 0) ?
                                      SYNC_BYTE : BYTE_W'($urandom_range(0, 254)));
        id   = ($urandom_range(0, 9) < 8) ? cur_id : BYTE_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = cur_params + HEADER_LEN;
        else if (pick < 85) len = BYTE_W'($urandom_range(2, 8));
        else if (pick < 96) len = BYTE_W'($urandom_range(0, 1));
        else                len = BYTE_W'($urandom_range(0, 255));
        err   = ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(1, 255)) : '0;
        start = byte_stream.size();
        append_packet(id, len, err, $urandom_range(0, 7) != 0);
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, byte_stream.size() - start - 1))
                void'(byte_stream.pop_back());
    endfunction

    // Offer one byte and hold it until the block takes it. Valid stays high
    // into the next item unless that item starts with a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = pick_wait(gap_pct);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.parse_byte(b);
    endtask

    task automatic send_bytes(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_byte(byte_stream.pop_front());
        i_in_valid <= 1'b0;
    endtask

    // Wait until every expected result has been taken, then let the output
    // register settle before anything else touches the block.
    task automatic settle();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Both registers are written on back-to-back edges with the enable held high.
    task automatic write_regs(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] params);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_EXPECTED_ID;
        i_cfg_data  <= id;
        @(posedge i_clk);
        i_cfg_index <= REG_EXPECTED_PARAMS;
        i_cfg_data  <= params;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(REG_EXPECTED_ID, id);
        tracker.set_reg(REG_EXPECTED_PARAMS, params);
        cur_id     = id;
        cur_params = params;
    endtask

    initial begin : stimulus
        int unsigned count;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset register values. Line noise with
        // a lone sync byte, then FF taken as the ID (wrong ID), a length of one
        // (short length, verdict carries the error byte) and an empty packet,
        // which fails the size check against the reset count of 74.
        gap_pct   = 20;
        stall_pct <= 20;
        byte_stream.push_back(8'h00);
        byte_stream.push_back(SYNC_BYTE);
        byte_stream.push_back(8'h5A);
        append_packet(SYNC_BYTE, 8'd4, 8'h00, 1'b1);
        append_packet(RST_EXPECTED_ID, 8'd1, 8'h07, 1'b1);
        append_packet(RST_EXPECTED_ID, HEADER_LEN, 8'h00, 1'b1);
        send_bytes(byte_stream.size());
        settle();

        // A good one-parameter packet once the expected count matches.
        write_regs(RST_EXPECTED_ID, 8'd1);
        append_packet(RST_EXPECTED_ID, 8'd3, 8'h00, 1'b1);
        send_bytes(byte_stream.size());
        settle();

        // Random part. The first two settings are the register extremes and the
        // third is random; the rest keep parameter counts small so packets stay
        // short. Bytes left over from one setting start the next, so a register
        // change can land in the middle of a packet.
        for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
            case (s)
                0: write_regs(8'h00, 8'd0);
                1: write_regs(8'hFF, 8'd253);
                2: write_regs(BYTE_W'($urandom_range(0, 255)),
                              BYTE_W'($urandom_range(0, 253)));
                default: write_regs(($urandom_range(0, 3) == 0) ?
                                    RST_EXPECTED_ID : BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 6)));
            endcase
            // Rotate through no idling, sender gaps, receiver stalls and both.
            case (s % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 30; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 30; end
                default: begin gap_pct = 50; stall_pct <= 50; end
            endcase
            while (byte_stream.size() < BYTES_PER_SET) gen_packet();
            count = (s == NUM_SETTINGS - 1) ? byte_stream.size() : BYTES_PER_SET;
            send_bytes(count);
            settle();
        end

        $display("Summary: %0d bytes over %0d register settings, %0d parameter items checked.",
                 tracker.bytes_seen, NUM_SETTINGS + 2, tracker.params_seen);
        $display("Verdicts: ok %0d, wrong id %0d, short %0d, checksum %0d, servo error %0d, size %0d.",
                 tracker.verdicts[ST_OK], tracker.verdicts[ST_BAD_ID],
                 tracker.verdicts[ST_SHORT], tracker.verdicts[ST_CHECKSUM],
                 tracker.verdicts[ST_SERVOERR], tracker.verdicts[ST_SIZE]);
        if (tracker.fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
